/* design/maxrects_rectangle_packer_assert.svh */
// Assertion macros for the rectangle packer.
`ifndef MAXRECTS_RECTANGLE_PACKER_ASSERT_SVH
`define MAXRECTS_RECTANGLE_PACKER_ASSERT_SVH
`ifndef SYNTH
`define MRP_ASSERT(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("packer check failed");
`define MRP_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("packer implication failed");
`else
`define MRP_ASSERT(name, clk, rst, expr)
`define MRP_ASSERT_IMP(name, clk, rst, ante, cons)
`endif
`endif

/* design/mrp_pkg.sv */
// Shared types and constants of the rectangle packer.
package mrp_pkg;

  typedef logic [0:0] cfg_index_t;

  localparam cfg_index_t CFG_BIN_WIDTH  = 1'd0;
  localparam cfg_index_t CFG_BIN_HEIGHT = 1'd1;

  localparam int BIN_RESET = 1024;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_CAP   = 2'd2;

  typedef struct packed {
    logic fit_ok;
    logic overlap;
    logic holds;
  } geom_flags_t;

endpackage

/* design/mrp_geom_unit.sv */
// Shared geometry unit: short-side fit score, overlap and containment tests.
module mrp_geom_unit #(
  parameter int CB = 16
) (
  input  logic [4*CB-1:0]      box_a,
  input  logic [4*CB-1:0]      box_b,
  output logic signed [CB:0]   score,
  output mrp_pkg::geom_flags_t flags
);
  import mrp_pkg::*;

  logic [CB-1:0] ax, ay, aw, ah, bx, by, bw, bh;
  logic [CB:0] ar, at, br, bt;
  logic signed [CB:0] dw, dh;

  assign {ax, ay, aw, ah} = box_a;
  assign {bx, by, bw, bh} = box_b;
  assign ar = {1'b0, ax} + {1'b0, aw};
  assign at = {1'b0, ay} + {1'b0, ah};
  assign br = {1'b0, bx} + {1'b0, bw};
  assign bt = {1'b0, by} + {1'b0, bh};
  assign dw = $signed({1'b0, aw}) - $signed({1'b0, bw});
  assign dh = $signed({1'b0, ah}) - $signed({1'b0, bh});
  assign score = (dw < dh) ? dw : dh;

  always_comb begin
    flags.fit_ok  = (score >= 0);
    flags.overlap = !((bx >= ar) || (by >= at) || (ax >= br) || (ay >= bt));
    flags.holds   = (bx >= ax) && (by >= ay) && (br <= ar) && (bt <= at);
  end

endmodule

/* design/maxrects_rectangle_packer.sv */
// Top level of the rectangle packer: sequencer, stores and result port.
// Rectangle words are loaded one per cycle until the word marked last; the block then packs
// the job into the configured bin and stalls input until every result word is taken. Each
// placement round reads the rectangles and scans them for a fit against the free boxes,
// then splits the free boxes and prunes the new pieces, all through one geometry unit and
// single-port reads of the free and pending stores. A job also clears the positions before
// packing and sends out the result words afterwards.
`include "maxrects_rectangle_packer_assert.svh"
module maxrects_rectangle_packer #(
  parameter int MAX_RECTS   = 64,
  parameter int MAX_FREE    = 128,
  parameter int MAX_PENDING = 128,
  parameter int COORD_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  mrp_pkg::cfg_index_t cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                rect_valid,
  output logic                rect_stall,
  input  logic [15:0]         rect_width,
  input  logic [15:0]         rect_height,
  input  logic                last_rect,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [5:0]          rect_index,
  output logic [15:0]         pos_x,
  output logic [15:0]         pos_y,
  output logic                placed,
  output logic [1:0]          job_status,
  output logic                last_result
);
  import mrp_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int BW  = 4 * CB;
  localparam int RW  = $clog2(MAX_RECTS);
  localparam int RCW = $clog2(MAX_RECTS + 1);
  localparam int FW  = $clog2(MAX_FREE);
  localparam int FCW = $clog2(MAX_FREE + 1);
  localparam int PW  = $clog2(MAX_PENDING);
  localparam int PCW = $clog2(MAX_PENDING + 1);
  localparam int IW  = (FCW > PCW) ? FCW : PCW;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_SC_RRD, S_SC_REV, S_SC_FRD, S_SC_FEV,
    S_CH_RD, S_CH_LD, S_MV_RD, S_MV_WR, S_PUSH, S_SP_RD, S_SP_EV,
    S_P1_IRD, S_P1_ILD, S_P1_JRD, S_P1_JEV,
    S_P2_IRD, S_P2_ILD, S_P2_JRD, S_P2_JEV,
    S_P3_RD, S_P3_EV, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_t;

  state_t state;

  logic [CB-1:0]  bin_w, bin_h;
  logic [RCW-1:0] rect_count, n, r, round;
  logic [FCW-1:0] fc, f;
  logic [PCW-1:0] pc, j;
  logic [IW-1:0]  i;
  logic [FW-1:0]  bf, wslot;
  logic [RW-1:0]  br;
  logic [1:0]     k;
  logic           found, nofit, cap, from_choice;
  logic signed [CB:0] best;
  logic [CB-1:0]  szw, szh, bw, bh, ux, uy;
  logic [BW-1:0]  mbox, hold;

  logic [2*CB-1:0] size_mem [MAX_RECTS];
  logic [2*CB:0]   pos_mem  [MAX_RECTS];
  logic [BW-1:0]   free_mem [MAX_FREE];
  logic [BW-1:0]   pend_mem [MAX_PENDING];
  logic            live_mem [MAX_PENDING];

  logic [2*CB-1:0] size_rd;
  logic [2*CB:0]   pos_rd;
  logic [BW-1:0]   free_rd, pend_rd;
  logic            live_rd;

  logic            accept, size_we, pos_we, free_we, pend_we, live_we, live_wdata;
  logic [RW-1:0]   rect_raddr, pos_waddr;
  logic [2*CB:0]   pos_wdata;
  logic [FW-1:0]   free_raddr, free_waddr;
  logic [BW-1:0]   free_wdata, geo_a, geo_b, piece;
  logic [PW-1:0]   pend_raddr, live_waddr;
  logic            piece_ok, push_en;

  logic signed [CB:0] score;
  geom_flags_t        flags;

  logic [CB-1:0] mx, my, mw, mh;
  logic [CB:0]   mr, mt, ur, ut;

  assign accept     = rect_valid && !rect_stall;
  assign rect_stall = (state != S_IDLE);

  assign {mx, my, mw, mh} = mbox;
  assign mr = {1'b0, mx} + {1'b0, mw};
  assign mt = {1'b0, my} + {1'b0, mh};
  assign ur = {1'b0, ux} + {1'b0, bw};
  assign ut = {1'b0, uy} + {1'b0, bh};

  always_comb begin
    piece_ok = 1'b0;
    piece    = '0;
    case (k)
      2'd0: begin
        piece_ok = (ux > mx);
        piece    = {mx, my, CB'(ux - mx), mh};
      end
      2'd1: begin
        piece_ok = (uy > my);
        piece    = {mx, my, mw, CB'(uy - my)};
      end
      2'd2: begin
        piece_ok = (mr > ur);
        piece    = {CB'(ur), my, CB'(mr - ur), mh};
      end
      default: begin
        piece_ok = (mt > ut);
        piece    = {mx, CB'(ut), mw, CB'(mt - ut)};
      end
    endcase
  end

  assign push_en = (state == S_PUSH) && piece_ok;

  assign geo_a = (state == S_P1_JEV || state == S_P2_JEV) ? hold : free_rd;
  assign geo_b = (state == S_SC_FEV) ? {{(2*CB){1'b0}}, szw, szh} :
                 (state == S_SP_EV)  ? {ux, uy, bw, bh} : pend_rd;

  mrp_geom_unit #(.CB(CB)) u_geom (
    .box_a (geo_a),
    .box_b (geo_b),
    .score (score),
    .flags (flags)
  );

  always_comb begin
    size_we    = accept && (rect_count < RCW'(MAX_RECTS));
    rect_raddr = r[RW-1:0];
    pos_we     = 1'b0;
    pos_waddr  = r[RW-1:0];
    pos_wdata  = '0;
    free_we    = 1'b0;
    free_waddr = '0;
    free_wdata = free_rd;
    free_raddr = f[FW-1:0];
    pend_we    = push_en && (pc < PCW'(MAX_PENDING));
    pend_raddr = j[PW-1:0];
    live_we    = pend_we;
    live_waddr = pc[PW-1:0];
    live_wdata = 1'b1;
    unique case (state)
      S_CLR: begin
        pos_we     = 1'b1;
        free_we    = 1'b1;
        free_wdata = {{(2*CB){1'b0}}, bin_w, bin_h};
      end
      S_CH_RD:  free_raddr = bf;
      S_CH_LD: begin
        pos_we    = 1'b1;
        pos_waddr = br;
        pos_wdata = {free_rd[BW-1:2*CB], 1'b1};
      end
      S_MV_RD:  free_raddr = FW'(fc - FCW'(1));
      S_MV_WR: begin
        free_we    = 1'b1;
        free_waddr = wslot;
      end
      S_SP_RD, S_P1_IRD: free_raddr = i[FW-1:0];
      S_P1_JEV, S_P2_JEV: begin
        live_we    = live_rd && flags.holds && !(state == S_P2_JEV && IW'(j) == i);
        live_waddr = j[PW-1:0];
        live_wdata = 1'b0;
      end
      S_P2_IRD, S_P3_RD: pend_raddr = i[PW-1:0];
      S_P3_EV: begin
        free_we    = live_rd && (fc < FCW'(MAX_FREE));
        free_waddr = fc[FW-1:0];
        free_wdata = pend_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (size_we) size_mem[rect_count[RW-1:0]] <= {CB'(rect_width), CB'(rect_height)};
    size_rd <= size_mem[rect_raddr];
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rd <= pos_mem[rect_raddr];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_waddr] <= free_wdata;
    free_rd <= free_mem[free_raddr];
  end

  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pc[PW-1:0]] <= piece;
    if (live_we) live_mem[live_waddr] <= live_wdata;
    pend_rd <= pend_mem[pend_raddr];
    live_rd <= live_mem[pend_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bin_w        <= CB'(BIN_RESET);
      bin_h        <= CB'(BIN_RESET);
      rect_count   <= '0;
      cap          <= 1'b0;
      fc           <= '0;
      pc           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_BIN_WIDTH:  bin_w <= CB'(cfg_data);
          CFG_BIN_HEIGHT: bin_h <= CB'(cfg_data);
          default: ;
        endcase
      end
      if (push_en) begin
        if (pc < PCW'(MAX_PENDING)) pc <= pc + PCW'(1);
        else cap <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (rect_count < RCW'(MAX_RECTS)) rect_count <= rect_count + RCW'(1);
            else cap <= 1'b1;
            if (last_rect) begin
              n     <= (rect_count < RCW'(MAX_RECTS)) ? rect_count + RCW'(1) : rect_count;
              r     <= '0;
              state <= S_CLR;
            end
          end
        end
        S_CLR: begin
          if (r + RCW'(1) == n) begin
            r     <= '0;
            fc    <= FCW'(1);
            pc    <= '0;
            round <= '0;
            found <= 1'b0;
            nofit <= 1'b0;
            state <= S_SC_RRD;
          end else begin
            r <= r + RCW'(1);
          end
        end
        S_SC_RRD: state <= S_SC_REV;
        S_SC_REV: begin
          if (!pos_rd[0] && fc != '0) begin
            {szw, szh} <= size_rd;
            f          <= '0;
            state      <= S_SC_FRD;
          end else if (r + RCW'(1) < n) begin
            r     <= r + RCW'(1);
            state <= S_SC_RRD;
          end else if (found) begin
            state <= S_CH_RD;
          end else begin
            nofit <= 1'b1;
            r     <= '0;
            state <= S_OUT_RD;
          end
        end
        S_SC_FRD: state <= S_SC_FEV;
        S_SC_FEV: begin
          if (flags.fit_ok && (!found || score < best)) begin
            best  <= score;
            br    <= r[RW-1:0];
            bf    <= f[FW-1:0];
            bw    <= szw;
            bh    <= szh;
            found <= 1'b1;
          end
          if (f + FCW'(1) < fc) begin
            f     <= f + FCW'(1);
            state <= S_SC_FRD;
          end else if (r + RCW'(1) < n) begin
            r     <= r + RCW'(1);
            state <= S_SC_RRD;
          end else if (found || flags.fit_ok) begin
            state <= S_CH_RD;
          end else begin
            nofit <= 1'b1;
            r     <= '0;
            state <= S_OUT_RD;
          end
        end
        S_CH_RD: state <= S_CH_LD;
        S_CH_LD: begin
          mbox        <= free_rd;
          ux          <= free_rd[BW-1:3*CB];
          uy          <= free_rd[3*CB-1:2*CB];
          wslot       <= bf;
          from_choice <= 1'b1;
          state       <= S_MV_RD;
        end
        S_MV_RD: state <= S_MV_WR;
        S_MV_WR: begin
          fc    <= fc - FCW'(1);
          k     <= from_choice ? 2'd2 : 2'd0;
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (k == 2'd3) begin
            if (from_choice) i <= '0;
            from_choice <= 1'b0;
            state       <= S_SP_RD;
          end
          k <= k + 2'd1;
        end
        S_SP_RD: begin
          if (i >= IW'(fc)) begin
            i     <= '0;
            state <= S_P1_IRD;
          end else begin
            state <= S_SP_EV;
          end
        end
        S_SP_EV: begin
          if (flags.overlap) begin
            mbox  <= free_rd;
            wslot <= i[FW-1:0];
            state <= S_MV_RD;
          end else begin
            i     <= i + IW'(1);
            state <= S_SP_RD;
          end
        end
        S_P1_IRD: begin
          if (i >= IW'(fc)) begin
            i     <= '0;
            state <= S_P2_IRD;
          end else begin
            state <= S_P1_ILD;
          end
        end
        S_P1_ILD: begin
          hold  <= free_rd;
          j     <= '0;
          state <= S_P1_JRD;
        end
        S_P1_JRD: begin
          if (j >= pc) begin
            i     <= i + IW'(1);
            state <= S_P1_IRD;
          end else begin
            state <= S_P1_JEV;
          end
        end
        S_P1_JEV: begin
          j     <= j + PCW'(1);
          state <= S_P1_JRD;
        end
        S_P2_IRD: begin
          if (i >= IW'(pc)) begin
            i     <= '0;
            state <= S_P3_RD;
          end else begin
            state <= S_P2_ILD;
          end
        end
        S_P2_ILD: begin
          if (live_rd) begin
            hold  <= pend_rd;
            j     <= '0;
            state <= S_P2_JRD;
          end else begin
            i     <= i + IW'(1);
            state <= S_P2_IRD;
          end
        end
        S_P2_JRD: begin
          if (j >= pc) begin
            i     <= i + IW'(1);
            state <= S_P2_IRD;
          end else begin
            state <= S_P2_JEV;
          end
        end
        S_P2_JEV: begin
          j     <= j + PCW'(1);
          state <= S_P2_JRD;
        end
        S_P3_RD: begin
          if (i >= IW'(pc)) begin
            pc <= '0;
            r  <= '0;
            if (round + RCW'(1) < n) begin
              round <= round + RCW'(1);
              found <= 1'b0;
              state <= S_SC_RRD;
            end else begin
              state <= S_OUT_RD;
            end
          end else begin
            state <= S_P3_EV;
          end
        end
        S_P3_EV: begin
          if (live_rd) begin
            if (fc < FCW'(MAX_FREE)) fc <= fc + FCW'(1);
            else cap <= 1'b1;
          end
          i     <= i + IW'(1);
          state <= S_P3_RD;
        end
        S_OUT_RD: state <= S_OUT_LD;
        S_OUT_LD: begin
          rect_index   <= 6'(r);
          pos_x        <= 16'(pos_rd[2*CB:CB+1]);
          pos_y        <= 16'(pos_rd[CB:1]);
          placed       <= pos_rd[0];
          job_status   <= cap ? ST_CAP : (nofit ? ST_NOFIT : ST_OK);
          last_result  <= (r + RCW'(1) == n);
          result_valid <= 1'b1;
          state        <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            if (r + RCW'(1) == n) begin
              rect_count <= '0;
              cap        <= 1'b0;
              state      <= S_IDLE;
            end else begin
              r     <= r + RCW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MRP_ASSERT(a_counts_bounded, clk, rst, (fc <= FCW'(MAX_FREE)) && (pc <= PCW'(MAX_PENDING)))
  `MRP_ASSERT_IMP(a_valid_in_wait, clk, rst, result_valid, state == S_OUT_WAIT)
  `MRP_ASSERT_IMP(a_no_result_idle, clk, rst, !rect_stall, !result_valid)
  `MRP_ASSERT_IMP(a_choice_found, clk, rst, state == S_CH_RD, found)

endmodule
